// ===== rtl/core/dfmod_pkg.sv =====
`default_nettype none
package dfmod_pkg;
    localparam logic [10:0] EXP_ONES  = 11'h7ff;
    localparam logic [63:0] QUIET_NAN = 64'h7FF8000000000000;
    localparam int          QDEPTH    = 2;

    // classified request handed from front to back
    typedef struct packed {
        logic        done;      // result already known
        logic [63:0] result;
        logic        invalid;
        logic        sign;
        logic [52:0] xs;
        logic [52:0] ys;
        logic [12:0] ex;        // signed, at least 1 (subnormals take 1)
        logic [12:0] ey;
    } job_t;
endpackage
`default_nettype wire

// ===== rtl/core/double_fmod_unit.sv =====
// Channel | Direction | tdata fields (low bit up)
// s_      | in        | dividend_bits[63:0], divisor_bits[127:64]
// m_      | out       | remainder_bits[63:0]; tuser: invalid_op
// Special cases: the result is decided in the front; the back end takes the request
// from the queue when idle and goes straight to showing the result.
// Otherwise the back end takes the request, normalises subnormal significands,
// runs a restoring reduction over the exponent difference, renormalises, packs
// the result, then holds the result.
// A two-entry queue lets the front accept while the back iterates.
// Reset (aresetn low, synchronous) empties the queue and idles the back end.
`default_nettype none
module double_fmod_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // dividend_bits, divisor_bits
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // remainder_bits
    output logic              m_tuser    // invalid_op
);
    dfmod_pkg::job_t q_job;
    logic q_valid, q_ready;

    dfmod_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .xb(s_tdata[63:0]), .yb(s_tdata[127:64]),
        .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
    );

    dfmod_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_job(q_job), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_bits(m_tdata), .out_invalid(m_tuser)
    );
endmodule
`default_nettype wire

// ===== rtl/core/dfmod_front.sv =====
`default_nettype none
module dfmod_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [63:0]     xb,
    input  wire logic [63:0]     yb,
    output logic                 q_valid,
    input  wire logic            q_ready,
    output dfmod_pkg::job_t      q_job
);
    dfmod_pkg::job_t job_c;
    dfmod_pkg::job_t mem_reg [dfmod_pkg::QDEPTH];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic [10:0] ex, ey;
    logic [63:0] xm, ym;
    logic       push, pop;

    always_comb begin
        ex = xb[62:52];
        ey = yb[62:52];
        xm = {xb[62:0], 1'b0};
        ym = {yb[62:0], 1'b0};
        job_c = '0;
        job_c.sign = xb[63];
        job_c.xs = (ex == 11'd0) ? {1'b0, xb[51:0]} : {1'b1, xb[51:0]};
        job_c.ys = (ey == 11'd0) ? {1'b0, yb[51:0]} : {1'b1, yb[51:0]};
        job_c.ex = (ex == 11'd0) ? 13'd1 : {2'b00, ex};
        job_c.ey = (ey == 11'd0) ? 13'd1 : {2'b00, ey};
        if (ym == 64'd0 || (ey == dfmod_pkg::EXP_ONES && yb[51:0] != 52'd0)
            || ex == dfmod_pkg::EXP_ONES) begin
            job_c.done = 1'b1;
            job_c.result = dfmod_pkg::QUIET_NAN;
            job_c.invalid = 1'b1;
        end else if (xm <= ym) begin
            job_c.done = 1'b1;
            job_c.result = (xm == ym) ? {xb[63], 63'd0} : xb;
        end
    end

    assign in_ready = (cnt_reg != 2'(dfmod_pkg::QDEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_job    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= job_c;
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/dfmod_back.sv =====
`default_nettype none
module dfmod_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire dfmod_pkg::job_t q_job,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [63:0]          out_bits,
    output logic                 out_invalid
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_NORM = 6'b000010, S_RED = 6'b000100,
        S_FIX  = 6'b001000, S_PACK = 6'b010000, S_OUT = 6'b100000
    } state_t;
    state_t state_reg;
    logic [53:0] xs_reg, ys_reg;
    logic signed [13:0] ex_reg, ey_reg;
    logic sign_reg;
    logic [63:0] res_reg;
    logic inv_reg;
    logic [54:0] diff;
    logic [12:0] sh;

    assign q_ready     = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign out_bits    = res_reg;
    assign out_invalid = inv_reg;
    assign diff = {1'b0, xs_reg} - {1'b0, ys_reg};
    assign sh   = 13'(14'sd1 - ex_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: if (q_valid) begin
                    xs_reg <= {1'b0, q_job.xs};
                    ys_reg <= {1'b0, q_job.ys};
                    ex_reg <= 14'($signed(q_job.ex));
                    ey_reg <= 14'($signed(q_job.ey));
                    sign_reg <= q_job.sign;
                    res_reg <= q_job.result;
                    inv_reg <= q_job.invalid;
                    state_reg <= q_job.done ? S_OUT : S_NORM;
                end
                S_NORM: begin
                    // one bit a cycle for both subnormal significands
                    if (xs_reg[52] && ys_reg[52]) state_reg <= S_RED;
                    if (!xs_reg[52]) begin
                        xs_reg <= xs_reg << 1; ex_reg <= ex_reg - 14'sd1;
                    end
                    if (!ys_reg[52]) begin
                        ys_reg <= ys_reg << 1; ey_reg <= ey_reg - 14'sd1;
                    end
                end
                S_RED: begin
                    if (!diff[54] && diff[53:0] == 54'd0) begin
                        res_reg <= {sign_reg, 63'd0};
                        state_reg <= S_OUT;
                    end else begin
                        if (ex_reg > ey_reg) begin
                            xs_reg <= (diff[54] ? xs_reg : diff[53:0]) << 1;
                            ex_reg <= ex_reg - 14'sd1;
                        end else begin
                            if (!diff[54]) xs_reg <= diff[53:0];
                            state_reg <= S_FIX;
                        end
                    end
                end
                S_FIX: begin
                    if (xs_reg[52]) state_reg <= S_PACK;
                    else begin
                        xs_reg <= xs_reg << 1; ex_reg <= ex_reg - 14'sd1;
                    end
                end
                S_PACK: begin
                    if (ex_reg > 14'sd0)
                        res_reg <= {sign_reg, ex_reg[10:0], xs_reg[51:0]};
                    else if (sh > 13'd63)
                        res_reg <= {sign_reg, 63'd0};
                    else
                        res_reg <= {sign_reg, 10'd0, xs_reg[52:0] >> sh[5:0]};
                    state_reg <= S_OUT;
                end
                S_OUT: if (out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/dfmod_checker.sv =====
`default_nettype none
module dfmod_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [127:0] s_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [63:0]  m_tdata,
    input wire logic         m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_nan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == dfmod_pkg::QUIET_NAN)
        else $error("invalid without nan");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("valid after reset");
endmodule

bind double_fmod_unit dfmod_checker u_chk (.*);
`default_nettype wire
